// ===== hw/rtl/rtbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtbp_pkg
// Types and constants shared by the RGB threshold bit packer.
// ----------------------------------------------------------------------------
package rtbp_pkg;

  localparam int CHAN_W      = 8;
  localparam int LUMA_W      = 8;
  localparam int PROD_W      = 16;   // 255 * 256 still fits
  localparam int PIX_CNT_W   = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;

  // BT.601 luma weights, scaled by 256
  localparam logic [7:0] COEF_R = 8'd77;
  localparam logic [7:0] COEF_G = 8'd150;
  localparam logic [7:0] COEF_B = 8'd29;

  localparam logic [LUMA_W-1:0]    THRESH_RESET = 8'd128;
  localparam logic [PIX_CNT_W-1:0] FRAME_RESET  = 24'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUMA_THRESHOLD = 2'd0,
    REG_FRAME_PIXELS   = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       frame_last;
  } result_t;

endpackage

// ===== hw/rtl/rtbp_luma_bit.sv =====
// ----------------------------------------------------------------------------
// rtbp_luma_bit
// Luma from one RGB pixel and its compare against the threshold.
// ----------------------------------------------------------------------------
module rtbp_luma_bit (
  input  rtbp_pkg::pixel_t                 pix,
  input  logic [rtbp_pkg::LUMA_W-1:0]      thresh,
  output logic                             bit_out
);

  logic [rtbp_pkg::PROD_W-1:0] prod_r_w;
  logic [rtbp_pkg::PROD_W-1:0] prod_g_w;
  logic [rtbp_pkg::PROD_W-1:0] prod_b_w;
  logic [rtbp_pkg::PROD_W-1:0] luma_sum;

  assign prod_r_w = {8'd0, pix.red}   * {8'd0, rtbp_pkg::COEF_R};
  assign prod_g_w = {8'd0, pix.green} * {8'd0, rtbp_pkg::COEF_G};
  assign prod_b_w = {8'd0, pix.blue}  * {8'd0, rtbp_pkg::COEF_B};
  assign luma_sum = prod_r_w + prod_g_w + prod_b_w;

  // luma is the high byte of the weighted sum
  assign bit_out = (luma_sum[rtbp_pkg::PROD_W-1 -: rtbp_pkg::LUMA_W] >= thresh);

endmodule

// ===== hw/rtl/rgb_threshold_bit_packer.sv =====
// ----------------------------------------------------------------------------
// rgb_threshold_bit_packer
// Threshold RGB pixels on luma and pack the bits MSB first into bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_stall/in_data) carry one RGB pixel each. Output
//   beats (out_valid/out_stall/out_data) carry one packed byte: the first
//   pixel of the byte sits in bit seven. A byte leaves after every eighth
//   pixel, and a short byte, zero in its low bits, closes the frame once
//   frame_pixels pixels have come in; frame_last marks it.
//   The input register loads at the input beat and the luma/compare/pack
//   logic feeds the output register from it, so each byte passes through
//   the input register and then the output register. Throughput is one
//   pixel per clock, set by the single input register feeding the output
//   register, while no held output byte stalls the input.
//   A held output byte stalls the input only when the pixel in the input
//   register would produce another byte; pixels that make no byte keep
//   flowing.
//   Reset: threshold 128, frame size 8, pixel counter and partial byte zero,
//   both pipeline registers empty. frame_pixels of zero means 2^24 pixels.
//   Write configuration only while no pixel is in flight.
// ----------------------------------------------------------------------------
module rgb_threshold_bit_packer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rtbp_pkg::pixel_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rtbp_pkg::result_t                   out_data,
  input  logic                                cfg_wr_en,
  input  logic [rtbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtbp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [rtbp_pkg::LUMA_W-1:0]    thresh_r;
  logic [rtbp_pkg::PIX_CNT_W-1:0] frame_r;
  logic [rtbp_pkg::PIX_CNT_W-1:0] pix_idx_r,   pix_idx_nxt;
  logic [7:0]                     partial_r,   partial_nxt;
  logic                           s1_valid_r,  s1_valid_nxt;
  rtbp_pkg::pixel_t               s1_pix_r;
  logic                           out_valid_r, out_valid_nxt;
  rtbp_pkg::result_t              out_data_r;

  logic                           pix_bit;
  logic [2:0]                     bit_pos;
  logic [rtbp_pkg::PIX_CNT_W:0]   count;
  logic [rtbp_pkg::PIX_CNT_W:0]   limit;
  logic                           frame_end;
  logic                           emit;
  logic                           s1_go;
  logic                           in_fire;
  logic [7:0]                     byte_bits;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= rtbp_pkg::THRESH_RESET;
      frame_r  <= rtbp_pkg::FRAME_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rtbp_pkg::REG_LUMA_THRESHOLD: thresh_r <= cfg_wdata[rtbp_pkg::LUMA_W-1:0];
        rtbp_pkg::REG_FRAME_PIXELS:   frame_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rtbp_luma_bit u_luma_bit (
    .pix     (s1_pix_r),
    .thresh  (thresh_r),
    .bit_out (pix_bit)
  );

  assign bit_pos   = pix_idx_r[2:0];
  assign count     = {1'b0, pix_idx_r} + 25'd1;
  assign limit     = {(frame_r == '0), frame_r};
  assign frame_end = (count >= limit);
  assign emit      = (bit_pos == 3'd7) || frame_end;
  assign byte_bits = partial_r | ({7'd0, pix_bit} << (3'd7 - bit_pos));

  // advance the input register unless its byte has nowhere to go
  assign s1_go    = s1_valid_r && (!emit || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    pix_idx_nxt   = pix_idx_r;
    partial_nxt   = partial_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
      if (emit) begin
        out_valid_nxt = 1'b1;
        partial_nxt   = '0;
        pix_idx_nxt   = frame_end ? '0 : count[rtbp_pkg::PIX_CNT_W-1:0];
      end else begin
        partial_nxt   = byte_bits;
        pix_idx_nxt   = count[rtbp_pkg::PIX_CNT_W-1:0];
      end
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pix_idx_r   <= '0;
      partial_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pix_idx_r   <= pix_idx_nxt;
      partial_r   <= partial_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r <= in_data;
    end
    if (s1_go && emit) begin
      out_data_r.packed_byte <= byte_bits;
      out_data_r.frame_last  <= frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // a byte boundary always starts with an empty partial byte
  a_boundary_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_idx_r[2:0] == 3'd0) |-> (partial_r == 8'd0))
    else $error("partial byte not empty at byte boundary");

  // closing a frame restarts the pixel counter
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && frame_end) |=> (pix_idx_r == '0))
    else $error("pixel counter did not restart after frame end");

  // the input only stalls behind a held pixel
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && emit && out_valid_r && out_stall))
    else $error("input stalled without a blocked byte");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB threshold bit packer: pixels go in on bursty
// beats, a luma/threshold/packing predictor builds the expected bytes, and each
// output beat is checked against the oldest one while the output side stalls.
// ----------------------------------------------------------------------------
module tb;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  rtbp_pkg::pixel_t                in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  rtbp_pkg::result_t               out_data;
  logic                            cfg_wr_en = 1'b0;
  logic [rtbp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rtbp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  rgb_threshold_bit_packer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the configuration and packing state
  logic [rtbp_pkg::LUMA_W-1:0]    thr_cfg   = rtbp_pkg::THRESH_RESET;
  logic [rtbp_pkg::PIX_CNT_W-1:0] frame_cfg = rtbp_pkg::FRAME_RESET;
  logic [rtbp_pkg::PIX_CNT_W-1:0] pix_idx   = '0;
  logic [7:0]                     bits_acc  = '0;

  rtbp_pkg::pixel_t  pixel_q[$];
  rtbp_pkg::result_t byte_q[$];
  int                errors = 0;
  int                bytes_seen = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    errors++;
  endtask

  task automatic pack_pixel(input rtbp_pkg::pixel_t p);
    logic [15:0]       luma_sum;
    logic [7:0]        luma;
    logic [2:0]        pos;
    logic [24:0]       count;
    logic [24:0]       limit;
    logic              last;
    rtbp_pkg::result_t res;
    luma_sum = {8'd0, p.red} * {8'd0, rtbp_pkg::COEF_R}
             + {8'd0, p.green} * {8'd0, rtbp_pkg::COEF_G}
             + {8'd0, p.blue} * {8'd0, rtbp_pkg::COEF_B};
    luma  = luma_sum[15:8];
    pos   = pix_idx[2:0];
    count = {1'b0, pix_idx} + 25'd1;
    // zero frame size means the full counter range
    limit = (frame_cfg == '0) ? 25'h1000000 : {1'b0, frame_cfg};
    last  = count >= limit;
    if (luma >= thr_cfg) bits_acc[3'd7 - pos] = 1'b1;
    if (pos == 3'd7 || last) begin
      res.packed_byte = bits_acc;
      res.frame_last  = last;
      byte_q.push_back(res);
      bits_acc = '0;
      pix_idx  = last ? '0 : count[23:0];
    end else begin
      pix_idx = count[23:0];
    end
  endtask

  task automatic write_reg(input rtbp_pkg::cfg_reg_t idx,
                           input logic [rtbp_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      rtbp_pkg::REG_LUMA_THRESHOLD: thr_cfg   = data[7:0];
      rtbp_pkg::REG_FRAME_PIXELS:   frame_cfg = data[23:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    rtbp_pkg::pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    pixel_q.push_back(p);
  endtask

  task automatic wait_drained(input int bound);
    int n;
    n = 0;
    while ((pixel_q.size() != 0 || in_valid || byte_q.size() != 0) && n < bound) begin
      @(posedge clk);
      n++;
    end
    // let pixels that make no byte clear the pipeline
    repeat (4) @(posedge clk);
  endtask

  // driver: bursts of beats with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : drive_pixels
    logic             take;
    logic             nxt_valid;
    rtbp_pkg::pixel_t nxt_data;
    take      = in_valid && !in_stall;
    nxt_valid = in_valid && !take;
    nxt_data  = in_data;
    if (rst_n) begin
      if (take) pack_pixel(in_data);
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pixel_q.size() != 0) begin
          nxt_data  = pixel_q.pop_front();
          nxt_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // monitor: check each byte beat, stall on a pattern of its own
  int         hold_left = 0;
  logic       held_once = 1'b0;
  logic [8:0] stall_phase = '0;

  always @(posedge clk) begin : check_bytes
    rtbp_pkg::result_t want;
    logic              nxt_stall;
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (byte_q.size() == 0) begin
        report_mismatch("byte with nothing pending", int'(out_data), 0);
      end else begin
        want = byte_q.pop_front();
        if (out_data.packed_byte !== want.packed_byte)
          report_mismatch("packed_byte", int'(out_data.packed_byte),
                          int'(want.packed_byte));
        if (out_data.frame_last !== want.frame_last)
          report_mismatch("frame_last", int'(out_data.frame_last),
                          int'(want.frame_last));
      end
    end
    stall_phase++;
    if (hold_left != 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (!held_once && bytes_seen >= 8 && pixel_q.size() >= 20) begin
      // hold off long enough for the input side to back up
      held_once = 1'b1;
      hold_left = 400;
      nxt_stall = 1'b1;
    end else begin
      case (stall_phase[8:7])
        2'd0:    nxt_stall = 1'b0;
        2'd1:    nxt_stall = ($urandom_range(0, 2) == 0);
        2'd2:    nxt_stall = ($urandom_range(0, 3) != 0);
        default: nxt_stall = stall_phase[2];
      endcase
    end
    out_stall <= nxt_stall;
  end

  initial begin : run_test
    int ph;
    int k;
    int n_items;
    int v;
    logic [7:0] t;
    logic [23:0] rnd;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: threshold 128, frame of 8
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd255);
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd127, 8'd127, 8'd127);
    push_pixel(8'd255, 8'd255, 8'd0);
    wait_drained(100000);

    // short frame: zero padding in the low bits
    write_reg(rtbp_pkg::REG_LUMA_THRESHOLD, 24'hFFFF_FF);
    write_reg(rtbp_pkg::REG_FRAME_PIXELS, 24'd3);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd254, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd255);
    wait_drained(100000);

    write_reg(rtbp_pkg::REG_LUMA_THRESHOLD, 24'd0);
    write_reg(rtbp_pkg::REG_FRAME_PIXELS, 24'd1);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd0);
    wait_drained(100000);

    // full-range frame, then the largest size, then shrink it mid-frame
    write_reg(rtbp_pkg::REG_LUMA_THRESHOLD, 24'd128);
    write_reg(rtbp_pkg::REG_FRAME_PIXELS, 24'd0);
    for (k = 0; k < 10; k++) begin
      rnd = 24'($urandom);
      push_pixel(rnd[23:16], rnd[15:8], rnd[7:0]);
    end
    wait_drained(100000);
    write_reg(rtbp_pkg::REG_FRAME_PIXELS, 24'hFFFFFF);
    for (k = 0; k < 3; k++) begin
      rnd = 24'($urandom);
      push_pixel(rnd[23:16], rnd[15:8], rnd[7:0]);
    end
    wait_drained(100000);
    write_reg(rtbp_pkg::REG_FRAME_PIXELS, 24'd5);
    push_pixel(8'd200, 8'd10, 8'd90);
    wait_drained(100000);

    for (ph = 0; ph < 12; ph++) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       t = 8'd0;
          1:       t = 8'd255;
          default: t = 8'($urandom);
        endcase
        rnd = 24'($urandom);
        write_reg(rtbp_pkg::REG_LUMA_THRESHOLD, {rnd[15:0], t});
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       rnd = 24'd0;
          1:       rnd = 24'hFFFFFF;
          2:       rnd = 24'd1;
          3:       rnd = 24'($urandom_range(1, 8));
          default: rnd = 24'($urandom_range(1, 40));
        endcase
        write_reg(rtbp_pkg::REG_FRAME_PIXELS, rnd);
      end
      n_items = $urandom_range(30, 55);
      for (k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 3) != 0) begin
          rnd = 24'($urandom);
          push_pixel(rnd[23:16], rnd[15:8], rnd[7:0]);
        end else begin
          // gray lands on or near the threshold boundary
          v = int'(thr_cfg) + $urandom_range(0, 4) - 2;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          push_pixel(8'(v), 8'(v), 8'(v));
        end
      end
      wait_drained(100000);
    end

    wait_drained(20000);
    if (byte_q.size() != 0) report_mismatch("bytes never emitted", 0, byte_q.size());
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("tb: errors");
    $finish;
  end

endmodule
